// ===== rtl/core/pspc_pkg.sv =====
`default_nettype none

package pspc_pkg;

  localparam int DEF_MAX_SLOTS   = 256;
  localparam int DEF_NUM_MODULES = 16;

  localparam int PID_W   = 22;
  localparam int MOD_W   = 4;
  localparam int MASK_W  = 32;
  localparam int LIMIT_W = 9;
  localparam int SLOT_W  = 8;
  localparam int COUNT_W = 9;

  localparam logic [LIMIT_W-1:0] POOL_LIMIT_RESET = 9'd256;

  // input beat layout
  localparam int IN_DATA_W = 32;
  localparam int IN_USER_W = 2;
  localparam int IN_PID_LSB = 0;
  localparam int IN_MOD_LSB = PID_W;

  // output beat layout
  localparam int OUT_DATA_W    = 64;
  localparam int OUT_STAT_LSB  = 0;
  localparam int OUT_SLOT_LSB  = 2;
  localparam int OUT_BITS_LSB  = OUT_SLOT_LSB + SLOT_W;
  localparam int OUT_STILL_LSB = OUT_BITS_LSB + MASK_W;
  localparam int OUT_OCC_LSB   = OUT_STILL_LSB + 1;
  localparam int OUT_FREED_LSB = OUT_OCC_LSB + COUNT_W;
  localparam int OUT_USED_W    = OUT_FREED_LSB + COUNT_W;

  typedef enum logic [1:0] {
    OP_ATTACH  = 2'd0,
    OP_RELEASE = 2'd1,
    OP_LOOKUP  = 2'd2,
    OP_SWEEP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/pid_slot_pool_with_compaction_top.sv =====
`default_nettype none

// Dense pool of process slots keyed by pid, each holding a 32-bit module mask
// (module m owns bit 2*m). Occupied slots always form the range 0..occupied-1;
// freeing a slot moves the last occupied slot into the hole. One slot memory
// with a single registered read port is walked by a small sequencer, and the
// block takes one beat at a time (s_tready is high only between operations).
// Attach, release and lookup first search the occupied slots for the pid (the
// search reads one slot per cycle), then act and go through S_DONE back to
// idle. A release that frees a slot other than the last then moves the last
// slot into it (read, then write). Sweep reads and checks each slot it visits
// and moves the last slot into each freed hole. A finished result waits in
// S_DONE until the output register is free; once it sits there, a new beat is
// taken while it waits. The slot memory needs no clearing after reset.
// cfg_data writes pool_limit (new slots are only allocated below
// min(pool_limit, MAX_SLOTS)); write it only while the block is idle.
module pid_slot_pool_with_compaction_top
  import pspc_pkg::*;
#(
  parameter int MAX_SLOTS   = DEF_MAX_SLOTS,
  parameter int NUM_MODULES = DEF_NUM_MODULES
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // pid[21:0], module_req[25:22], zero pad
  input  wire logic [IN_USER_W-1:0]  s_tuser,   // operation[1:0]
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // status[1:0], slot[9:2], module_bits[41:10],
                                                // still_tracked[42], occupied[51:43],
                                                // freed_count[60:52], zero pad
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [LIMIT_W-1:0]    cfg_data   // pool_limit
);

  localparam int IW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int OCW = $clog2(MAX_SLOTS + 1);
  localparam int CW  = (OCW > LIMIT_W) ? OCW : LIMIT_W;
  localparam int ENTRY_W = PID_W + MASK_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_ACT, S_MV_RD, S_MV_WR, S_SW_RD, S_SW_CHK, S_DONE
  } state_t;

  state_t               state;
  op_t                  op;
  logic [PID_W-1:0]     pid_q;
  logic [MASK_W-1:0]    bit_q;
  logic [LIMIT_W-1:0]   pool_limit;
  logic [OCW-1:0]       occ;
  logic [OCW-1:0]       freed;
  logic [OCW-1:0]       scan_idx;
  logic [IW-1:0]        chk_idx;
  logic                 chk_valid;
  logic [OCW-1:0]       cur;
  logic                 found;
  logic [MASK_W-1:0]    hit_mask;
  status_t              res_status;
  logic [SLOT_W-1:0]    res_slot;
  logic [MASK_W-1:0]    res_bits;
  logic                 res_still;

  logic [ENTRY_W-1:0]   mem [MAX_SLOTS];
  logic [ENTRY_W-1:0]   rd_data;
  logic [IW-1:0]        rd_addr;
  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  logic [ENTRY_W-1:0]   wr_data;

  logic [PID_W-1:0]     rd_pid;
  logic [MASK_W-1:0]    rd_mask;
  logic                 hit;
  logic                 mod_ok_in;
  logic [MOD_W-1:0]     mod_in;
  op_t                  op_in;
  logic                 occ_full;
  logic                 at_over;
  logic [MASK_W-1:0]    mask_set;
  logic [MASK_W-1:0]    mask_clr;
  logic [MASK_W-1:0]    sw_clr;
  logic                 out_load;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  assign rd_pid    = rd_data[ENTRY_W-1 -: PID_W];
  assign rd_mask   = rd_data[MASK_W-1:0];
  assign hit       = chk_valid && (rd_pid == pid_q);
  assign mod_in    = s_tdata[IN_MOD_LSB +: MOD_W];
  assign op_in     = op_t'(s_tuser);
  assign mod_ok_in = ({1'b0, mod_in} < (MOD_W + 1)'(NUM_MODULES));
  assign occ_full  = (CW'(occ) >= CW'(pool_limit)) || (occ >= OCW'(MAX_SLOTS));
  assign at_over   = (CW'(cur) >= CW'(pool_limit));
  assign mask_set  = hit_mask | bit_q;
  assign mask_clr  = hit_mask & ~bit_q;
  assign sw_clr    = rd_mask & ~bit_q;
  assign out_load  = (state == S_DONE) && (!m_tvalid || m_tready);

  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    case (state)
      S_SCAN: begin
        if (!hit && scan_idx < occ) rd_addr = scan_idx[IW-1:0];
      end
      S_ACT: begin
        case (op)
          OP_ATTACH: begin
            if (found && !at_over) begin
              wr_en   = 1'b1;
              wr_addr = cur[IW-1:0];
              wr_data = {pid_q, mask_set};
            end else if (!found && !occ_full) begin
              wr_en   = 1'b1;
              wr_addr = occ[IW-1:0];
              wr_data = {pid_q, bit_q};
            end
          end
          OP_RELEASE: begin
            if (found && hit_mask != '0 && mask_clr != '0) begin
              wr_en   = 1'b1;
              wr_addr = cur[IW-1:0];
              wr_data = {pid_q, mask_clr};
            end
          end
          default: ;
        endcase
      end
      S_MV_RD: rd_addr = occ[IW-1:0];
      S_MV_WR: begin
        wr_en   = 1'b1;
        wr_addr = cur[IW-1:0];
        wr_data = rd_data;
      end
      S_SW_RD: begin
        if (cur < occ) rd_addr = cur[IW-1:0];
      end
      S_SW_CHK: begin
        if ((rd_mask & bit_q) != '0 && sw_clr != '0) begin
          wr_en   = 1'b1;
          wr_addr = cur[IW-1:0];
          wr_data = {rd_pid, sw_clr};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      occ        <= '0;
      pool_limit <= POOL_LIMIT_RESET;
      chk_valid  <= 1'b0;
    end else begin
      if (cfg_valid) pool_limit <= cfg_data;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op         <= op_in;
            pid_q      <= s_tdata[IN_PID_LSB +: PID_W];
            bit_q      <= MASK_W'(1) << {mod_in, 1'b0};
            res_slot   <= '0;
            res_bits   <= '0;
            res_still  <= 1'b0;
            freed      <= '0;
            scan_idx   <= '0;
            chk_valid  <= 1'b0;
            cur        <= '0;
            found      <= 1'b0;
            if (op_in != OP_LOOKUP && !mod_ok_in) begin
              res_status <= ST_NOT_FOUND;
              state      <= S_DONE;
            end else if (op_in == OP_SWEEP) begin
              res_status <= ST_OK;
              state      <= S_SW_RD;
            end else begin
              res_status <= ST_OK;
              state      <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (hit) begin
            found     <= 1'b1;
            cur       <= OCW'(chk_idx);
            hit_mask  <= rd_mask;
            chk_valid <= 1'b0;
            state     <= S_ACT;
          end else if (scan_idx < occ) begin
            chk_idx   <= scan_idx[IW-1:0];
            chk_valid <= 1'b1;
            scan_idx  <= scan_idx + 1'b1;
          end else if (chk_valid) begin
            chk_valid <= 1'b0;
          end else begin
            state <= S_ACT;
          end
        end
        S_ACT: begin
          if (op == OP_RELEASE && found && hit_mask != '0 && mask_clr == '0 &&
              cur != occ - 1'b1) state <= S_MV_RD;
          else state <= S_DONE;
          case (op)
            OP_ATTACH: begin
              if (found) begin
                if (at_over) begin
                  res_status <= ST_FULL;
                end else begin
                  res_slot <= SLOT_W'(cur);
                  res_bits <= mask_set;
                end
              end else if (occ_full) begin
                res_status <= ST_FULL;
              end else begin
                res_slot <= SLOT_W'(occ);
                res_bits <= bit_q;
                occ      <= occ + 1'b1;
              end
            end
            OP_RELEASE: begin
              if (!found) begin
                res_status <= ST_NOT_FOUND;
              end else if (hit_mask == '0) begin
                res_status <= ST_EMPTY;
                res_slot   <= SLOT_W'(cur);
              end else begin
                res_slot <= SLOT_W'(cur);
                if (mask_clr != '0) begin
                  res_still <= 1'b1;
                  res_bits  <= mask_clr;
                end else begin
                  occ <= occ - 1'b1;
                end
              end
            end
            OP_LOOKUP: begin
              if (found) begin
                res_slot <= SLOT_W'(cur);
                res_bits <= hit_mask;
              end else begin
                res_status <= ST_NOT_FOUND;
              end
            end
            default: ;
          endcase
        end
        S_MV_RD: state <= S_MV_WR;
        S_MV_WR: state <= (op == OP_SWEEP) ? S_SW_RD : S_DONE;
        S_SW_RD: state <= (cur < occ) ? S_SW_CHK : S_DONE;
        S_SW_CHK: begin
          if ((rd_mask & bit_q) == '0 || sw_clr != '0) begin
            cur   <= cur + 1'b1;
            state <= S_SW_RD;
          end else begin
            occ   <= occ - 1'b1;
            freed <= freed + 1'b1;
            if (cur != occ - 1'b1) state <= S_MV_RD;
            else state <= S_SW_RD;
          end
        end
        S_DONE: begin
          if (out_load) begin
            m_tdata  <= {(OUT_DATA_W - OUT_USED_W)'(0), COUNT_W'(freed), COUNT_W'(occ),
                         res_still, res_bits, res_slot, res_status};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= OCW'(MAX_SLOTS))
    else $error("occupied count above capacity");

  a_wr_dense: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (OCW'(wr_addr) <= occ))
    else $error("slot write outside the dense range");

  a_occ_report: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (m_tvalid && m_tdata[OUT_OCC_LSB +: COUNT_W] == $past(COUNT_W'(occ))))
    else $error("reported occupied count differs from pool state");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_SW_RD || state == S_MV_WR) |-> !s_tready)
    else $error("beat accepted during an operation");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pspc_pkg::*;

  localparam int SLOTS = DEF_MAX_SLOTS;
  localparam int IDLE_LIMIT = 20000;
  localparam int RX_HOLD_AT = 150;
  localparam int RX_HOLD_CYCLES = 400;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [MASK_W-1:0]  bits;
    logic               still;
    logic [COUNT_W-1:0] occupied;
    logic [COUNT_W-1:0] freed;
  } reply_t;

  class pool_scoreboard;
    logic [PID_W-1:0]  pid_of [SLOTS];
    logic [MASK_W-1:0] mask_of [SLOTS];
    int occ;
    int limit;
    int errors;
    int replies;
    reply_t expected_replies[$];

    function new();
      occ = 0;
      limit = POOL_LIMIT_RESET;
      errors = 0;
      replies = 0;
    endfunction

    function int find_pid(logic [PID_W-1:0] pid);
      for (int i = 0; i < occ; i++)
        if (pid_of[i] == pid) return i;
      return -1;
    endfunction

    // swap-remove: last occupied slot fills the hole
    function void drop_slot(int i);
      occ--;
      if (i != occ) begin
        pid_of[i] = pid_of[occ];
        mask_of[i] = mask_of[occ];
      end
    endfunction

    function void predict_op(op_t op, logic [PID_W-1:0] pid, logic [MOD_W-1:0] m);
      reply_t r;
      int at;
      int eff;
      int i;
      logic [MASK_W-1:0] bitm;
      r = '0;
      bitm = 32'd1 << (2 * m);
      eff = (limit < SLOTS) ? limit : SLOTS;
      at = find_pid(pid);
      if (op != OP_LOOKUP && m >= DEF_NUM_MODULES) begin
        r.status = ST_NOT_FOUND;
      end else begin
        case (op)
          OP_ATTACH: begin
            if (at >= 0) begin
              if (at >= eff) begin
                r.status = ST_FULL;
              end else begin
                mask_of[at] = mask_of[at] | bitm;
                r.slot = SLOT_W'(at);
                r.bits = mask_of[at];
              end
            end else if (occ >= eff) begin
              r.status = ST_FULL;
            end else begin
              pid_of[occ] = pid;
              mask_of[occ] = bitm;
              r.slot = SLOT_W'(occ);
              r.bits = bitm;
              occ++;
            end
          end
          OP_RELEASE: begin
            if (at < 0) begin
              r.status = ST_NOT_FOUND;
            end else if (mask_of[at] == '0) begin
              r.status = ST_EMPTY;
              r.slot = SLOT_W'(at);
            end else begin
              r.slot = SLOT_W'(at);
              mask_of[at] = mask_of[at] & ~bitm;
              if (mask_of[at] != '0) begin
                r.still = 1'b1;
                r.bits = mask_of[at];
              end else begin
                drop_slot(at);
              end
            end
          end
          OP_LOOKUP: begin
            if (at >= 0) begin
              r.slot = SLOT_W'(at);
              r.bits = mask_of[at];
            end else begin
              r.status = ST_NOT_FOUND;
            end
          end
          default: begin
            i = 0;
            while (i < occ) begin
              if ((mask_of[i] & bitm) == '0) begin
                i++;
              end else begin
                mask_of[i] = mask_of[i] & ~bitm;
                if (mask_of[i] != '0) begin
                  i++;
                end else begin
                  drop_slot(i);
                  r.freed++;
                end
              end
            end
          end
        endcase
      end
      r.occupied = occ[COUNT_W-1:0];
      expected_replies.push_back(r);
    endfunction

    function void compare(string name, longint unsigned e, longint unsigned a);
      if (e != a) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, e, a);
      end
    endfunction

    function void check_reply(logic [OUT_DATA_W-1:0] d);
      reply_t e;
      if (expected_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, expected none actual %0h", $time, d);
        return;
      end
      e = expected_replies.pop_front();
      replies++;
      compare("status", e.status, d[OUT_STAT_LSB +: 2]);
      compare("slot", e.slot, d[OUT_SLOT_LSB +: SLOT_W]);
      compare("module_bits", e.bits, d[OUT_BITS_LSB +: MASK_W]);
      compare("still_tracked", e.still, d[OUT_STILL_LSB]);
      compare("occupied", e.occupied, d[OUT_OCC_LSB +: COUNT_W]);
      compare("freed_count", e.freed, d[OUT_FREED_LSB +: COUNT_W]);
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [IN_USER_W-1:0]  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [LIMIT_W-1:0]    cfg_data;

  pool_scoreboard sb;
  bit send_burst;

  pid_slot_pool_with_compaction_top dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic issue_op(op_t op, logic [PID_W-1:0] pid, logic [MOD_W-1:0] m);
    int gap;
    if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 11);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = op;
    s_tdata = {{(IN_DATA_W - PID_W - MOD_W){1'b0}}, m, pid};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.predict_op(op, pid, m);
  endtask

  // drain all pending replies, then write pool_limit with the block idle
  task automatic write_pool_limit(int v);
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.expected_replies.size() != 0) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = LIMIT_W'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.limit = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [PID_W-1:0] known_pid();
    if (sb.occ == 0 || $urandom_range(0, 9) == 0) return PID_W'($urandom_range(0, 22'h3FFFFF));
    return sb.pid_of[$urandom_range(0, sb.occ - 1)];
  endfunction

  // mostly a module the slot actually holds, sometimes any module
  function automatic logic [MOD_W-1:0] held_module(logic [PID_W-1:0] pid,
                                                   logic [MOD_W-1:0] m);
    int at;
    logic [MOD_W-1:0] k;
    at = sb.find_pid(pid);
    if (at < 0 || $urandom_range(0, 3) == 0) return m;
    k = m;
    repeat (DEF_NUM_MODULES) begin
      if (sb.mask_of[at][2 * k]) return k;
      k++;
    end
    return m;
  endfunction

  task automatic random_op(int w_new, int w_att, int w_rel, int w_look, int w_sweep);
    int r;
    logic [PID_W-1:0] pid;
    logic [MOD_W-1:0] m;
    r = $urandom_range(0, w_new + w_att + w_rel + w_look + w_sweep - 1);
    pid = known_pid();
    m = MOD_W'($urandom_range(0, 15));
    if (r < w_new)
      issue_op(OP_ATTACH, PID_W'($urandom_range(0, 22'h3FFFFF)), m);
    else if (r < w_new + w_att)
      issue_op(OP_ATTACH, pid, m);
    else if (r < w_new + w_att + w_rel)
      issue_op(OP_RELEASE, pid, held_module(pid, m));
    else if (r < w_new + w_att + w_rel + w_look)
      issue_op(OP_LOOKUP, pid, m);
    else
      issue_op(OP_SWEEP, PID_W'($urandom_range(0, 22'h3FFFFF)), m);
  endtask

  // result side: random backpressure plus one long hold to fill the block
  initial begin
    int gap;
    bit held;
    bit burst;
    held = 1'b0;
    burst = 1'b0;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && sb.replies >= RX_HOLD_AT) begin
        held = 1'b1;
        m_tready = 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
      end
      if ($urandom_range(0, 24) == 0) burst = !burst;
      gap = burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        m_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready = 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      sb.check_reply(m_tdata);
      @(negedge clk);
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    sb = new();
    send_burst = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_ATTACH;
    cfg_valid = 1'b0;
    cfg_data = POOL_LIMIT_RESET;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty pool, field extremes, bit not held, swap-remove, last-slot free
    issue_op(OP_LOOKUP, 22'h0, 4'd0);
    issue_op(OP_RELEASE, 22'h0, 4'd0);
    issue_op(OP_SWEEP, 22'h0, 4'd0);
    issue_op(OP_ATTACH, 22'h0, 4'd0);
    issue_op(OP_ATTACH, 22'h3FFFFF, 4'd15);
    issue_op(OP_ATTACH, 22'h0, 4'd15);
    issue_op(OP_ATTACH, 22'h0, 4'd15);
    issue_op(OP_LOOKUP, 22'h3FFFFF, 4'd9);
    issue_op(OP_RELEASE, 22'h3FFFFF, 4'd3);
    issue_op(OP_ATTACH, 22'h155555, 4'd7);
    issue_op(OP_ATTACH, 22'h2AAAAA, 4'd8);
    issue_op(OP_RELEASE, 22'h0, 4'd0);
    issue_op(OP_RELEASE, 22'h0, 4'd15);
    issue_op(OP_LOOKUP, 22'h2AAAAA, 4'd0);
    issue_op(OP_RELEASE, 22'h2AAAAA, 4'd8);
    issue_op(OP_RELEASE, 22'h155555, 4'd7);
    issue_op(OP_ATTACH, 22'h1, 4'd1);
    issue_op(OP_RELEASE, 22'h1, 4'd1);
    issue_op(OP_SWEEP, 22'h0, 4'd15);

    // pool full and limit lowered under an occupied slot
    write_pool_limit(1);
    issue_op(OP_ATTACH, 22'h5, 4'd2);
    issue_op(OP_ATTACH, 22'h6, 4'd4);
    write_pool_limit(2);
    issue_op(OP_ATTACH, 22'h6, 4'd4);
    write_pool_limit(1);
    issue_op(OP_ATTACH, 22'h6, 4'd5);
    issue_op(OP_ATTACH, 22'h5, 4'd3);
    issue_op(OP_SWEEP, 22'h0, 4'd2);

    // fill the whole pool
    write_pool_limit(SLOTS);
    repeat (300) random_op(90, 3, 0, 7, 0);

    write_pool_limit($urandom_range(20, 60));
    repeat (60) random_op(15, 30, 25, 20, 10);

    write_pool_limit(SLOTS);
    repeat (50) random_op(5, 15, 35, 10, 35);

    write_pool_limit(1);
    repeat (20) random_op(30, 30, 20, 10, 10);

    write_pool_limit(3);
    repeat (20) random_op(30, 30, 20, 10, 10);

    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.expected_replies.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (sb.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
